/* sv/stid_pkg.sv */
// Shared types and constants for the sorted table insert/delete core.
package stid_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VAL_W     = 32;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_REM_IDX = 2'd1,
    CMD_REM_VAL = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE         = 2'd0,
    ST_DROP_LARGEST = 2'd1,
    ST_DROP_NEW     = 2'd2,
    ST_MISS         = 2'd3
  } status_t;

  typedef struct packed {
    logic                    ins_en;
    logic                    rm_en;
    logic                    rm_by_idx;
    logic signed [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

/* sv/stid_cell.sv */
// One table slot: holds an entry and its valid bit, shifts with its neighbors.
module stid_cell #(
  parameter int IDX_W = 4,
  parameter int POS   = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  stid_pkg::cell_ctl_t              ctl,
  input  logic [IDX_W-1:0]                 rm_index,
  input  logic signed [stid_pkg::VAL_W-1:0] prev_entry,
  input  logic                             prev_valid,
  input  logic                             prev_gt,
  input  logic signed [stid_pkg::VAL_W-1:0] next_entry,
  input  logic                             next_valid,
  output logic signed [stid_pkg::VAL_W-1:0] entry,
  output logic                             valid,
  output logic                             gt,
  output logic                             match,
  output logic signed [stid_pkg::VAL_W-1:0] entry_nxt,
  output logic                             valid_nxt
);

  logic signed [stid_pkg::VAL_W-1:0] entry_r;
  logic                              valid_r;
  logic                              ge;
  logic                              shift_dn;

  assign entry = entry_r;
  assign valid = valid_r;
  assign gt    = valid_r && (entry_r > ctl.value);
  assign ge    = valid_r && (entry_r >= ctl.value);
  assign match = valid_r && (entry_r == ctl.value);

  assign shift_dn = ctl.rm_by_idx ? (IDX_W'(POS) >= rm_index) : ge;

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (ctl.ins_en) begin
      if (prev_gt) begin
        entry_nxt = prev_entry;
      end else if (gt || !valid_r) begin
        entry_nxt = ctl.value;
      end
      valid_nxt = valid_r | prev_valid;
    end else if (ctl.rm_en && shift_dn) begin
      entry_nxt = next_entry;
      valid_nxt = next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    entry_r <= entry_nxt;
  end

endmodule

/* sv/sorted_table_insert_delete_core.sv */
// Top level of the sorted table insert/delete core: command decode and cell chain.
//
// Keeps up to DEPTH signed 32-bit entries in ascending order in a row of cells.
// Input channel: a request is taken at a rising edge with start high and busy
// low. in_command selects insert (after equal entries), remove at in_index, or
// remove the first entry equal to in_value.
// Every cell compares its entry with the broadcast value and takes its own,
// its lower or its upper neighbor's entry, or the new value, in the same cycle,
// so each request is finished at the edge that takes it. busy stays low: a new
// request can be taken every cycle.
// Result channel: exactly one result per request, shown with out_valid high for
// one cycle, the cycle after the request edge. out_status gives done, largest
// dropped, new value dropped or miss; out_count the occupancy afterwards;
// out_smallest the entry at position zero, or zero on an empty table.
// The receiver cannot stall; results are never held.
// Reset (rst_n low, synchronous) empties the table and drops any pending
// result; entry contents are not cleared, only valid bits.
module sorted_table_insert_delete_core #(
  parameter int DEPTH = stid_pkg::DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH),
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_command,
  input  logic signed [stid_pkg::VAL_W-1:0] in_value,
  input  logic [IDX_W-1:0]                 in_index,
  output logic                             out_valid,
  output logic [1:0]                       out_status,
  output logic [CNT_W-1:0]                 out_count,
  output logic signed [stid_pkg::VAL_W-1:0] out_smallest
);

  logic signed [stid_pkg::VAL_W-1:0] entry   [DEPTH];
  logic signed [stid_pkg::VAL_W-1:0] e_nxt   [DEPTH];
  logic [DEPTH-1:0]                  valid;
  logic [DEPTH-1:0]                  v_nxt;
  logic [DEPTH-1:0]                  gt;
  logic [DEPTH-1:0]                  match;

  stid_pkg::cell_ctl_t ctl;
  stid_pkg::status_t   status_nxt;
  logic                accept;
  logic                full;
  logic                any_gt;
  logic                found;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic                out_valid_r;
  logic [1:0]          out_status_r;
  logic signed [stid_pkg::VAL_W-1:0] out_smallest_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = valid[DEPTH-1];
  assign any_gt = |gt;
  assign found  = |match;

  always_comb begin
    ctl        = '0;
    ctl.value  = in_value;
    status_nxt = stid_pkg::ST_MISS;
    count_nxt  = count_r;
    case (in_command)
      stid_pkg::CMD_INSERT: begin
        if (full && !any_gt) begin
          status_nxt = stid_pkg::ST_DROP_NEW;
        end else begin
          ctl.ins_en = accept;
          if (full) begin
            status_nxt = stid_pkg::ST_DROP_LARGEST;
          end else begin
            status_nxt = stid_pkg::ST_DONE;
            count_nxt  = count_r + CNT_W'(1);
          end
        end
      end
      stid_pkg::CMD_REM_IDX: begin
        ctl.rm_by_idx = 1'b1;
        if (valid[in_index]) begin
          ctl.rm_en  = accept;
          status_nxt = stid_pkg::ST_DONE;
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      stid_pkg::CMD_REM_VAL: begin
        if (found) begin
          ctl.rm_en  = accept;
          status_nxt = stid_pkg::ST_DONE;
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      default: begin
        status_nxt = stid_pkg::ST_MISS;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [stid_pkg::VAL_W-1:0] p_entry;
    logic                              p_valid;
    logic                              p_gt;
    logic signed [stid_pkg::VAL_W-1:0] n_entry;
    logic                              n_valid;

    if (i == 0) begin : g_first
      assign p_entry = '0;
      assign p_valid = 1'b1;
      assign p_gt    = 1'b0;
    end else begin : g_mid
      assign p_entry = entry[i-1];
      assign p_valid = valid[i-1];
      assign p_gt    = gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign n_entry = '0;
      assign n_valid = 1'b0;
    end else begin : g_up
      assign n_entry = entry[i+1];
      assign n_valid = valid[i+1];
    end

    stid_cell #(
      .IDX_W(IDX_W),
      .POS  (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .rm_index  (in_index),
      .prev_entry(p_entry),
      .prev_valid(p_valid),
      .prev_gt   (p_gt),
      .next_entry(n_entry),
      .next_valid(n_valid),
      .entry     (entry[i]),
      .valid     (valid[i]),
      .gt        (gt[i]),
      .match     (match[i]),
      .entry_nxt (e_nxt[i]),
      .valid_nxt (v_nxt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
    if (accept) begin
      out_status_r   <= status_nxt;
      out_smallest_r <= v_nxt[0] ? e_nxt[0] : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_count    = count_r;
  assign out_smallest = out_smallest_r;

endmodule

/* sv/stid_checker.sv */
// Port-level checker for the sorted table insert/delete core, bound to the top level.
module stid_checker #(
  parameter int DEPTH = stid_pkg::DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH),
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             out_valid,
  input logic [1:0]                       out_status,
  input logic [CNT_W-1:0]                 out_count,
  input logic signed [stid_pkg::VAL_W-1:0] out_smallest
);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("request without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without request");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= CNT_W'(DEPTH))
    else $error("count above depth");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == stid_pkg::ST_DROP_LARGEST ||
                   out_status == stid_pkg::ST_DROP_NEW))
      |-> out_count == CNT_W'(DEPTH))
    else $error("drop status on a table that is not full");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_count == '0) |-> out_smallest == '0)
    else $error("nonzero smallest on empty table");

endmodule

bind sorted_table_insert_delete_core stid_checker #(
  .DEPTH(DEPTH),
  .IDX_W(IDX_W),
  .CNT_W(CNT_W)
) u_stid_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_status  (out_status),
  .out_count   (out_count),
  .out_smallest(out_smallest)
);
